// File: sv/stepper_axis_position_tracker_assert.svh
// Assertion macros shared by the position tracker modules.
`ifndef STEPPER_AXIS_POSITION_TRACKER_ASSERT_SVH
`define STEPPER_AXIS_POSITION_TRACKER_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define STPAX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define STPAX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STPAX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/stpax_pkg.sv
// Shared types and constants of the stepper axis position tracker.
package stpax_pkg;

  // Fixed field widths
  localparam int unsigned ACTION_BITS   = 3;
  localparam int unsigned TARGET_BITS   = 32;
  localparam int unsigned OUT_POS_BITS  = 16;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [CFG_DATA_BITS-1:0] MAX_POSITION_RESET = 16'd20000;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_TICK = 3'd0,
    ACT_ABS  = 3'd1,
    ACT_INC  = 3'd2,
    ACT_ZERO = 3'd3,
    ACT_HOLD = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MOTOR_MAPPING = 1'b0,
    REG_MAX_POSITION  = 1'b1
  } reg_idx_e;

  typedef logic [OUT_POS_BITS-1:0] out_pos_t;

  // One input transaction
  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [TARGET_BITS-1:0] target;
    logic                   positive_limit_hit;
    logic                   negative_limit_hit;
    logic                   motor_stepped;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic     stepped;
    logic     blocked;
    logic     moving_positive;
    logic     motor_clockwise;
    out_pos_t axis_position;
    out_pos_t goal_position;
    logic     at_target;
  } result_t;

endpackage

// File: sv/stpax_core.sv
// Input register, configuration and axis state with the per-item update logic.
module stpax_core #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [stpax_pkg::CFG_IDX_BITS-1:0]     cfg_addr_i,
  input  logic [stpax_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i,
  input  logic                                   in_valid_i,
  input  stpax_pkg::item_t                       item_i,
  output logic                                   in_stall_o,
  output logic                                   res_valid_o,
  output stpax_pkg::result_t                     res_o,
  input  logic                                   res_stall_i
);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [stpax_pkg::TARGET_BITS-1:0] word_t;

  localparam word_t PosMask = word_t'((64'd1 << POSITION_BITS) - 64'd1);

  logic                                 item_valid_q;
  stpax_pkg::item_t                     item_q;
  logic                                 fire;
  logic                                 mapping_q;
  logic [stpax_pkg::CFG_DATA_BITS-1:0]  max_q;
  pos_t                                 now_q, now_d;
  pos_t                                 goal_q, goal_d;
  logic                                 dir_q, dir_d;
  logic                                 stepped, blocked;
  word_t                                now_w, goal_w, move_w, limit_w, sat_w, max_w;
  logic                                 move_skip;

  // Input register: holds while the result side is full
  assign in_stall_o = item_valid_q && res_stall_i;
  assign fire       = item_valid_q && !res_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapping_q <= 1'b0;
      max_q     <= stpax_pkg::MAX_POSITION_RESET;
    end else if (cfg_we_i) begin
      case (stpax_pkg::reg_idx_e'(cfg_addr_i))
        stpax_pkg::REG_MOTOR_MAPPING: mapping_q <= cfg_wdata_i[0];
        stpax_pkg::REG_MAX_POSITION:  max_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Move target: absolute or goal plus increment, then saturated
  assign now_w   = word_t'(now_q);
  assign goal_w  = word_t'(goal_q);
  assign max_w   = word_t'(max_q);
  assign move_w  = (stpax_pkg::action_e'(item_q.action) == stpax_pkg::ACT_INC)
                   ? goal_w + item_q.target : item_q.target;
  assign limit_w = (max_w < PosMask) ? max_w : PosMask;
  assign sat_w   = (move_w > limit_w) ? limit_w : move_w;
  assign move_skip = (move_w == goal_w) || (move_w == now_w);

  // Next state for the registered item
  always_comb begin
    now_d   = now_q;
    goal_d  = goal_q;
    dir_d   = dir_q;
    stepped = 1'b0;
    blocked = 1'b0;
    case (stpax_pkg::action_e'(item_q.action))
      stpax_pkg::ACT_TICK: begin
        if (now_q != goal_q) begin
          if (((now_q < goal_q) && item_q.positive_limit_hit) ||
              ((now_q > goal_q) && item_q.negative_limit_hit)) begin
            goal_d  = now_q;
            blocked = 1'b1;
          end else if (item_q.motor_stepped) begin
            now_d   = dir_q ? now_q + pos_t'(1) : now_q - pos_t'(1);
            stepped = 1'b1;
          end
        end
      end
      stpax_pkg::ACT_ABS, stpax_pkg::ACT_INC: begin
        if (!move_skip) begin
          goal_d = pos_t'(sat_w);
          dir_d  = pos_t'(sat_w) > now_q;
        end
      end
      stpax_pkg::ACT_ZERO: begin
        now_d  = '0;
        goal_d = '0;
      end
      stpax_pkg::ACT_HOLD: begin
        goal_d = now_q;
      end
      default: ;
    endcase
  end

  // Axis state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q  <= '0;
      goal_q <= '0;
      dir_q  <= 1'b1;
    end else if (fire) begin
      now_q  <= now_d;
      goal_q <= goal_d;
      dir_q  <= dir_d;
    end
  end

  // Result shows the state after the item
  assign res_valid_o               = fire;
  assign res_o.stepped             = stepped;
  assign res_o.blocked             = blocked;
  assign res_o.moving_positive     = dir_d;
  assign res_o.motor_clockwise     = dir_d ^ mapping_q;
  assign res_o.axis_position       = stpax_pkg::out_pos_t'(now_d);
  assign res_o.goal_position       = stpax_pkg::out_pos_t'(goal_d);
  assign res_o.at_target           = (now_d == goal_d);

`include "stepper_axis_position_tracker_assert.svh"

  `STPAX_ASSERT_IMP(a_step_xor_block, fire, !(stepped && blocked), "step and block in one item")
  `STPAX_ASSERT_IMP(a_block_on_target, fire && blocked, res_o.at_target, "block left axis off target")
  `STPAX_ASSERT_NXT(a_state_holds, !fire, $stable(now_q) && $stable(goal_q), "state moved without item")

endmodule

// File: sv/stpax_skid.sv
// Result register with a skid entry so the input side runs ahead of stalls.
module stpax_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  stpax_pkg::result_t  in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output stpax_pkg::result_t  out_data_o,
  input  logic                out_stall_i
);

  logic               main_valid_q, main_valid_d;
  logic               skid_valid_q, skid_valid_d;
  stpax_pkg::result_t main_q, skid_q;
  logic               accept, take, load_main, load_skid, pop_skid;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign take       = main_valid_q && !out_stall_i;
  assign pop_skid   = skid_valid_q && take;
  assign load_main  = accept && (!main_valid_q || take);
  assign load_skid  = accept && main_valid_q && !take;

  // Occupancy
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop_skid) begin
      skid_valid_d = 1'b0;
    end else if (load_main) begin
      main_valid_d = 1'b1;
    end else if (load_skid) begin
      skid_valid_d = 1'b1;
    end else if (take) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (pop_skid) begin
      main_q <= skid_q;
    end else if (load_main) begin
      main_q <= in_data_i;
    end
    if (load_skid) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

`include "stepper_axis_position_tracker_assert.svh"

  `STPAX_ASSERT_IMP(a_skid_needs_main, skid_valid_q, main_valid_q, "skid entry without result entry")
  `STPAX_ASSERT_NXT(a_take_clears_skid, take, !skid_valid_q, "skid entry left after a take")
  `STPAX_ASSERT_NXT(a_stall_keeps_main, main_valid_q && out_stall_i, main_valid_q, "stalled result lost")

endmodule

// File: sv/stepper_axis_position_tracker.sv
// Top level of the stepper axis position tracker.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-------------------------------------------
//  input   | in_valid_i  | in_stall_o  | action_i target_i *_limit_hit_i motor_stepped_i
//  result  | out_valid_o | out_stall_i | stepped_o .. at_target_o
//  config  | cfg_we_i    | none        | cfg_addr_i cfg_wdata_i
//
// One item per cycle unless in_stall_o; each item gives one result via the
// input register, then the result register holding the updated axis state.
// The state update is combinational: compare, increment and saturation.
// Reset clears position and target to zero, direction to positive, mapping to
// zero and the maximum position to 20000.
// A stalled result side fills one skid entry, then in_stall_o rises.
module stepper_axis_position_tracker #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [stpax_pkg::CFG_IDX_BITS-1:0]   cfg_addr_i,
  input  logic [stpax_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [stpax_pkg::ACTION_BITS-1:0]    action_i,
  input  logic [stpax_pkg::TARGET_BITS-1:0]    target_i,
  input  logic                                 positive_limit_hit_i,
  input  logic                                 negative_limit_hit_i,
  input  logic                                 motor_stepped_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 stepped_o,
  output logic                                 blocked_o,
  output logic                                 moving_positive_o,
  output logic                                 motor_clockwise_o,
  output stpax_pkg::out_pos_t                  axis_position_o,
  output stpax_pkg::out_pos_t                  goal_position_o,
  output logic                                 at_target_o
);

  stpax_pkg::item_t   item;
  stpax_pkg::result_t res, res_out;
  logic               res_valid, res_stall;

  assign item.action             = action_i;
  assign item.target             = target_i;
  assign item.positive_limit_hit = positive_limit_hit_i;
  assign item.negative_limit_hit = negative_limit_hit_i;
  assign item.motor_stepped      = motor_stepped_i;

  stpax_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .item_i      (item),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_stall_i (res_stall)
  );

  stpax_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_stall_o  (res_stall),
    .out_valid_o (out_valid_o),
    .out_data_o  (res_out),
    .out_stall_i (out_stall_i)
  );

  assign stepped_o          = res_out.stepped;
  assign blocked_o          = res_out.blocked;
  assign moving_positive_o  = res_out.moving_positive;
  assign motor_clockwise_o  = res_out.motor_clockwise;
  assign axis_position_o    = res_out.axis_position;
  assign goal_position_o    = res_out.goal_position;
  assign at_target_o        = res_out.at_target;

endmodule

// File: tb/sv/tb_stepper_axis_position_tracker.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stepper axis position tracker.

// Scoreboard: tracks the axis state, queues expected results, checks outputs
class axis_tracker_sb;
  bit                 map_cw_negative;
  logic [15:0]        max_steps;
  logic [15:0]        pos_now;
  logic [15:0]        pos_goal;
  bit                 heading_pos;
  stpax_pkg::result_t expected_reports[$];
  int                 mismatch_count;

  function new();
    map_cw_negative = 1'b0;
    max_steps       = stpax_pkg::MAX_POSITION_RESET;
    pos_now         = '0;
    pos_goal        = '0;
    heading_pos     = 1'b1;
    mismatch_count  = 0;
  endfunction

  function void write_reg(stpax_pkg::reg_idx_e idx, logic [15:0] data);
    case (idx)
      stpax_pkg::REG_MOTOR_MAPPING: map_cw_negative = data[0];
      stpax_pkg::REG_MAX_POSITION:  max_steps = data;
      default: ;
    endcase
  endfunction

  // Move to a destination, for absolute and increment moves; full 32-bit compare happens before saturation
  function void seek(logic [31:0] dest);
    logic [15:0] goal;
    if (dest == {16'd0, pos_goal} || dest == {16'd0, pos_now}) return;
    goal = (dest > {16'd0, max_steps}) ? max_steps : dest[15:0];
    pos_goal    = goal;
    heading_pos = (pos_goal > pos_now);
  endfunction

  // Apply one accepted command and queue the state it reports
  function void track_command(stpax_pkg::item_t cmd);
    stpax_pkg::result_t rep;
    rep = '0;
    case (cmd.action)
      stpax_pkg::ACT_TICK: begin
        if (pos_now != pos_goal) begin
          if ((pos_now < pos_goal && cmd.positive_limit_hit) ||
              (pos_now > pos_goal && cmd.negative_limit_hit)) begin
            pos_goal    = pos_now;
            rep.blocked = 1'b1;
          end else if (cmd.motor_stepped) begin
            pos_now     = heading_pos ? pos_now + 16'd1 : pos_now - 16'd1;
            rep.stepped = 1'b1;
          end
        end
      end
      stpax_pkg::ACT_ABS:  seek(cmd.target);
      stpax_pkg::ACT_INC:  seek({16'd0, pos_goal} + cmd.target);
      stpax_pkg::ACT_ZERO: begin
        pos_now  = '0;
        pos_goal = '0;
      end
      stpax_pkg::ACT_HOLD: pos_goal = pos_now;
      default: ;
    endcase
    rep.moving_positive = heading_pos;
    rep.motor_clockwise = heading_pos ^ map_cw_negative;
    rep.axis_position   = pos_now;
    rep.goal_position   = pos_goal;
    rep.at_target       = (pos_now == pos_goal);
    expected_reports.push_back(rep);
  endfunction

  function void check_report(stpax_pkg::result_t got);
    stpax_pkg::result_t exp_rep;
    if (expected_reports.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result transaction: pos=%0d goal=%0d",
                 got.axis_position, got.goal_position);
      return;
    end
    exp_rep = expected_reports.pop_front();
    if (got.stepped !== exp_rep.stepped || got.blocked !== exp_rep.blocked ||
        got.moving_positive !== exp_rep.moving_positive ||
        got.motor_clockwise !== exp_rep.motor_clockwise ||
        got.axis_position !== exp_rep.axis_position ||
        got.goal_position !== exp_rep.goal_position ||
        got.at_target !== exp_rep.at_target) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch: expected stp=%0b blk=%0b pos_dir=%0b cw=%0b pos=%0d goal=%0d at=%0b",
                 exp_rep.stepped, exp_rep.blocked, exp_rep.moving_positive,
                 exp_rep.motor_clockwise, exp_rep.axis_position,
                 exp_rep.goal_position, exp_rep.at_target);
        $display("          actual   stp=%0b blk=%0b pos_dir=%0b cw=%0b pos=%0d goal=%0d at=%0b",
                 got.stepped, got.blocked, got.moving_positive, got.motor_clockwise,
                 got.axis_position, got.goal_position, got.at_target);
      end
    end
  endfunction
endclass

module tb_stepper_axis_position_tracker;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned PHASE_ITEMS     = 250;
  localparam int unsigned NUM_PHASES      = 5;
  localparam int unsigned ACT_BITS        = stpax_pkg::ACTION_BITS;
  localparam int unsigned ACT_SPARE_FIRST = stpax_pkg::ACT_HOLD + 1;
  localparam int unsigned ACT_SPARE_LAST  = (1 << stpax_pkg::ACTION_BITS) - 1;

  logic                                clk_i;
  logic                                rst_ni               = 1'b0;
  logic                                cfg_we_i             = 1'b0;
  logic [stpax_pkg::CFG_IDX_BITS-1:0]  cfg_addr_i           = '0;
  logic [stpax_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i          = '0;
  logic                                in_valid_i           = 1'b0;
  logic                                in_stall_o;
  logic [stpax_pkg::ACTION_BITS-1:0]   action_i             = '0;
  logic [stpax_pkg::TARGET_BITS-1:0]   target_i             = '0;
  logic                                positive_limit_hit_i = 1'b0;
  logic                                negative_limit_hit_i = 1'b0;
  logic                                motor_stepped_i      = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i          = 1'b0;
  logic                                stepped_o;
  logic                                blocked_o;
  logic                                moving_positive_o;
  logic                                motor_clockwise_o;
  stpax_pkg::out_pos_t                 axis_position_o;
  stpax_pkg::out_pos_t                 goal_position_o;
  logic                                at_target_o;

  axis_tracker_sb sb = new();
  bit             burst_mode = 1'b0;

  stepper_axis_position_tracker dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_addr_i           (cfg_addr_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .action_i             (action_i),
    .target_i             (target_i),
    .positive_limit_hit_i (positive_limit_hit_i),
    .negative_limit_hit_i (negative_limit_hit_i),
    .motor_stepped_i      (motor_stepped_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .stepped_o            (stepped_o),
    .blocked_o            (blocked_o),
    .moving_positive_o    (moving_positive_o),
    .motor_clockwise_o    (motor_clockwise_o),
    .axis_position_o      (axis_position_o),
    .goal_position_o      (goal_position_o),
    .at_target_o          (at_target_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle cycles before the next transaction, or result-side stall cycles; none during a burst stretch
  function automatic int draw_wait();
    return burst_mode ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic stpax_pkg::item_t mk(logic [stpax_pkg::ACTION_BITS-1:0] act,
                                          logic [31:0] tgt, bit plim, bit nlim,
                                          bit mstep);
    stpax_pkg::item_t c;
    c.action             = act;
    c.target             = tgt;
    c.positive_limit_hit = plim;
    c.negative_limit_hit = nlim;
    c.motor_stepped      = mstep;
    return c;
  endfunction

  // Mostly ticks with steps, moves near the current position, rare limits
  function automatic stpax_pkg::item_t rand_cmd();
    stpax_pkg::item_t c;
    int               pick;
    c = mk(stpax_pkg::ACT_TICK, $urandom, $urandom_range(0, 11) == 0,
           $urandom_range(0, 11) == 0, $urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      c.action = stpax_pkg::ACT_TICK;
    end else if (pick < 70) begin
      c.action = stpax_pkg::ACT_ABS;
      case ($urandom_range(0, 5))
        0: c.target = 32'(sb.pos_goal);
        1: c.target = 32'(sb.pos_now);
        2: c.target = 32'(sb.max_steps) + 32'($urandom_range(0, 2)) - 32'd1;
        3: ;
        default: c.target = 32'(sb.pos_now) + 32'($urandom_range(0, 80)) - 32'd40;
      endcase
    end else if (pick < 82) begin
      c.action = stpax_pkg::ACT_INC;
      case ($urandom_range(0, 3))
        0: c.target = 32'($urandom_range(0, 40));
        1: c.target = -32'($urandom_range(1, 40));
        2: c.target = 32'(sb.pos_now) - 32'(sb.pos_goal);
        default: ;
      endcase
    end else if (pick < 88) begin
      c.action = stpax_pkg::ACT_ZERO;
    end else if (pick < 94) begin
      c.action = stpax_pkg::ACT_HOLD;
    end else begin
      c.action = ACT_BITS'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    end
    return c;
  endfunction

  // Drive one input transaction and wait for its acceptance
  task automatic send_cmd(input stpax_pkg::item_t cmd);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    action_i             <= cmd.action;
    target_i             <= cmd.target;
    positive_limit_hit_i <= cmd.positive_limit_hit;
    negative_limit_hit_i <= cmd.negative_limit_hit;
    motor_stepped_i      <= cmd.motor_stepped;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.track_command(cmd);
  endtask

  // Stop sending until every expected result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_reports.size() != 0);
  endtask

  task automatic write_config(bit map_neg, logic [15:0] max_pos);
    logic [15:0] map_word;
    map_word    = {15'($urandom), map_neg};
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= stpax_pkg::REG_MOTOR_MAPPING;
    cfg_wdata_i <= map_word;
    @(posedge clk_i);
    sb.write_reg(stpax_pkg::REG_MOTOR_MAPPING, map_word);
    cfg_addr_i  <= stpax_pkg::REG_MAX_POSITION;
    cfg_wdata_i <= max_pos;
    @(posedge clk_i);
    sb.write_reg(stpax_pkg::REG_MAX_POSITION, max_pos);
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: random stall per transaction, check on every acceptance
  initial begin : result_sink
    int                 hold_off;
    stpax_pkg::result_t got;
    hold_off = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.stepped         = stepped_o;
        got.blocked         = blocked_o;
        got.moving_positive = moving_positive_o;
        got.motor_clockwise = motor_clockwise_o;
        got.axis_position   = axis_position_o;
        got.goal_position   = goal_position_o;
        got.at_target       = at_target_o;
        sb.check_report(got);
        hold_off = draw_wait();
      end
      if (hold_off > 0) begin
        out_stall_i <= 1'b1;
        hold_off--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    stpax_pkg::item_t directed[$];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: at-target tick, steps, blocks both ways, saturation, ignored moves, spare actions, hold, zero
    directed.push_back(mk(stpax_pkg::ACT_TICK, 32'd0, 1'b1, 1'b1, 1'b1));
    directed.push_back(mk(stpax_pkg::ACT_ABS, 32'd0, 1'b0, 1'b0, 1'b1));
    directed.push_back(mk(stpax_pkg::ACT_ABS, 32'd3, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(stpax_pkg::ACT_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1));
    directed.push_back(mk(stpax_pkg::ACT_TICK, 32'd0, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(stpax_pkg::ACT_TICK, 32'd0, 1'b0, 1'b1, 1'b1));
    directed.push_back(mk(stpax_pkg::ACT_TICK, 32'd0, 1'b1, 1'b0, 1'b1));
    directed.push_back(mk(stpax_pkg::ACT_ABS, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    directed.push_back(mk(stpax_pkg::ACT_INC, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(stpax_pkg::ACT_INC, 32'd1, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(stpax_pkg::ACT_ABS, 32'd2, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(stpax_pkg::ACT_ABS, 32'd1, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(stpax_pkg::ACT_TICK, 32'd0, 1'b1, 1'b0, 1'b1));
    directed.push_back(mk(stpax_pkg::ACT_ABS, 32'd0, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(stpax_pkg::ACT_TICK, 32'd0, 1'b1, 1'b1, 1'b1));
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
      directed.push_back(mk(ACT_BITS'(a), $urandom, 1'b1, 1'b0, 1'b1));
    directed.push_back(mk(stpax_pkg::ACT_ABS, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(stpax_pkg::ACT_TICK, 32'd0, 1'b0, 1'b1, 1'b1));
    directed.push_back(mk(stpax_pkg::ACT_HOLD, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    directed.push_back(mk(stpax_pkg::ACT_INC, 32'h0001_0000, 1'b0, 1'b0, 1'b0));
    directed.push_back(mk(stpax_pkg::ACT_ZERO, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    directed.push_back(mk(stpax_pkg::ACT_INC, 32'h0001_0000, 1'b0, 1'b0, 1'b0));
    foreach (directed[i]) send_cmd(directed[i]);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: write_config(1'b1, 16'hFFFF);
        1: write_config(1'b0, 16'd0);
        2: write_config(1'b1, 16'd37);
        3: write_config(1'b0, stpax_pkg::MAX_POSITION_RESET);
        default: write_config(1'($urandom), 16'($urandom));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        send_cmd(rand_cmd());
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/stpax_pkg.sv
sv/stpax_core.sv
sv/stpax_skid.sv
sv/stepper_axis_position_tracker.sv
tb/sv/tb_stepper_axis_position_tracker.sv
